// ===== rtl/core/xbts_pkg.sv =====
// xbts_pkg: shared types, opcode constants and the opcode classifier
// for the branch target scanner; used by every module in rtl/core
package xbts_pkg;

	localparam int WIN_DEPTH = 4;
	localparam int Q_DEPTH   = 4;
	localparam int Q_AW      = 2;

	localparam logic [7:0] OP_JMP8       = 8'hEB;
	localparam logic [7:0] OP_JCC_LO     = 8'h70;
	localparam logic [7:0] OP_JCC_HI     = 8'h7F;
	localparam logic [7:0] OP_CALL32     = 8'hE8;
	localparam logic [7:0] OP_JMP32      = 8'hE9;
	localparam logic [7:0] OP_PUSH_EBP   = 8'h55;
	localparam logic [7:0] OP_MOV        = 8'h8B;
	localparam logic [7:0] MODRM_EBP_ESP = 8'hEC;

	localparam logic [31:0] LEN_REL8  = 32'd2;
	localparam logic [31:0] LEN_REL32 = 32'd5;

	localparam logic [1:0] REG_TEXT_BASE = 2'd0;
	localparam logic [1:0] REG_CODE_SIZE = 2'd1;
	localparam logic [1:0] REG_REBASE    = 2'd2;

	// byte [0] is the opcode position
	typedef logic [WIN_DEPTH:0][7:0] win5_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] disp;
	} cls_t;

	typedef struct packed {
		logic        fin;
		logic [31:0] pos;
		logic [31:0] disp;
	} job_t;

	typedef struct packed {
		logic [31:0] text_base;
		logic [31:0] code_size;
		logic [31:0] rebase;
	} cfg_t;

	function automatic cls_t classify(input win5_t b);
		cls_t r;
		r.hit  = 1'b0;
		r.disp = '0;
		case (b[0]) inside
			OP_JMP8, [OP_JCC_LO:OP_JCC_HI]: begin
				r.hit  = 1'b1;
				r.disp = {{24{b[1][7]}}, b[1]} + LEN_REL8;
			end
			OP_CALL32, OP_JMP32: begin
				r.hit  = 1'b1;
				r.disp = {b[4], b[3], b[2], b[1]} + LEN_REL32;
			end
			OP_PUSH_EBP: begin
				r.hit  = (b[1] == OP_MOV) && (b[2] == MODRM_EBP_ESP);
				r.disp = '0;
			end
			default: begin
				r.hit  = 1'b0;
				r.disp = '0;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/xbts_front.sv =====
// xbts_front: byte window, opcode classification and end-of-run flush
// depends on xbts_pkg; pushes branch jobs into xbts_queue
module xbts_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          code_byte,
	input  logic                last,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                q_full,
	output logic                q_push,
	output xbts_pkg::job_t      q_data
);
	import xbts_pkg::*;

	logic [WIN_DEPTH-1:0][7:0] win_q;
	logic [2:0]                fill_q;
	logic [31:0]               pos_q;
	logic                      flushing_q;
	logic [2:0]                fl_left_q;
	logic [31:0]               fl_pos_q;
	win5_t                     fl_buf_q;

	win5_t       buf5;
	win5_t       src;
	cls_t        cls;
	logic        acc;
	logic        step;
	logic        full_win;
	logic [31:0] job_pos;

	assign in_stall = flushing_q | q_full;
	assign acc      = in_valid & ~in_stall;
	assign step     = flushing_q & ~q_full;
	assign full_win = (fill_q == 3'(WIN_DEPTH));

	// pending bytes, then the new byte, then zero padding
	always_comb begin
		for (int j = 0; j < WIN_DEPTH; j++) begin
			if (3'(j) < fill_q)
				buf5[j] = win_q[j];
			else if (3'(j) == fill_q)
				buf5[j] = code_byte;
			else
				buf5[j] = '0;
		end
		buf5[WIN_DEPTH] = full_win ? code_byte : 8'h00;
	end

	assign src     = flushing_q ? fl_buf_q : buf5;
	assign cls     = classify(src);
	assign job_pos = flushing_q ? fl_pos_q : (pos_q - 32'(WIN_DEPTH));

	always_comb begin
		q_push = 1'b0;
		if (acc && !last && full_win && cls.hit)
			q_push = 1'b1;
		if (step && (fl_left_q != 3'd0) && cls.hit)
			q_push = 1'b1;
		if (step && (fl_left_q == 3'd0))
			q_push = 1'b1;
		q_data.fin  = flushing_q && (fl_left_q == 3'd0);
		q_data.pos  = job_pos;
		q_data.disp = cls.disp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			pos_q      <= '0;
			flushing_q <= 1'b0;
			fl_left_q  <= '0;
		end else if (acc) begin
			if (last) begin
				flushing_q <= 1'b1;
				fl_left_q  <= fill_q + 3'd1;
				fill_q     <= '0;
				pos_q      <= '0;
			end else begin
				if (!full_win)
					fill_q <= fill_q + 3'd1;
				pos_q <= pos_q + 32'd1;
			end
		end else if (step) begin
			if (fl_left_q == 3'd0)
				flushing_q <= 1'b0;
			else
				fl_left_q <= fl_left_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			if (last) begin
				fl_buf_q <= buf5;
				fl_pos_q <= pos_q - {29'd0, fill_q};
			end else if (full_win) begin
				win_q <= {code_byte, win_q[WIN_DEPTH-1:1]};
			end else begin
				win_q[fill_q[1:0]] <= code_byte;
			end
		end else if (step && (fl_left_q != 3'd0)) begin
			fl_buf_q <= {8'h00, fl_buf_q[WIN_DEPTH:1]};
			fl_pos_q <= fl_pos_q + 32'd1;
		end
	end

endmodule

// ===== rtl/core/xbts_queue.sv =====
// xbts_queue: short job queue between front and back
// depends on xbts_pkg for the job type and depth
module xbts_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  xbts_pkg::job_t wr_data,
	output logic           full,
	input  logic           pop,
	output xbts_pkg::job_t head,
	output logic           empty
);
	import xbts_pkg::*;

	job_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];
	assign do_wr = push & ~full;
	assign do_rd = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("job pushed into full queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (Q_AW+1)'(Q_DEPTH))
		else $error("queue count out of range");

endmodule

// ===== rtl/core/xbts_back.sv =====
// xbts_back: target sum, range check, image rebase and entry numbering
// depends on xbts_pkg; drains jobs from xbts_queue
module xbts_back (
	input  logic                clk,
	input  logic                arst_n,
	input  xbts_pkg::cfg_t      cfg,
	input  xbts_pkg::job_t      q_head,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         target_addr,
	output logic [31:0]         entry_index,
	output logic                is_final
);
	import xbts_pkg::*;

	logic        valid_s1;
	logic        fin_s1;
	logic [31:0] t_s1;

	logic        out_valid_q;
	logic [31:0] target_q;
	logic [31:0] index_q;
	logic        final_q;
	logic [31:0] cnt_q;

	logic [31:0] range_end;
	logic        in_range;
	logic        emit_s1;
	logic        out_ready;
	logic        go_s1;

	assign range_end = cfg.text_base + cfg.code_size;
	assign in_range  = (t_s1 >= cfg.text_base) && (t_s1 < range_end);
	assign emit_s1   = fin_s1 | in_range;
	assign out_ready = ~out_valid_q | ~out_stall;
	assign go_s1     = ~valid_s1 | ~emit_s1 | out_ready;
	assign q_pop     = go_s1 & ~q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (go_s1)
				valid_s1 <= ~q_empty;
			if (out_ready) begin
				out_valid_q <= valid_s1 & emit_s1;
				if (valid_s1 && emit_s1)
					cnt_q <= fin_s1 ? 32'd0 : cnt_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			fin_s1 <= q_head.fin;
			t_s1   <= cfg.text_base + q_head.pos + q_head.disp;
		end
		if (out_ready && valid_s1 && emit_s1) begin
			target_q <= fin_s1 ? 32'd0 : t_s1 + cfg.rebase;
			index_q  <= cnt_q;
			final_q  <= fin_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign target_addr = target_q;
	assign entry_index = index_q;
	assign is_final    = final_q;

	a_cnt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ready && valid_s1 && fin_s1) |=> (cnt_q == 32'd0))
		else $error("entry count not cleared after final item");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ready && valid_s1 && !fin_s1 && in_range)
		|=> (cnt_q == $past(cnt_q) + 32'd1))
		else $error("entry count did not advance");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && emit_s1 && !out_ready) |=> (valid_s1 && $stable(t_s1)))
		else $error("stage 1 item lost under output stall");

endmodule

// ===== rtl/core/x86_branch_target_scanner.sv =====
// x86_branch_target_scanner: top level, configuration registers and wiring
// depends on xbts_pkg, xbts_front, xbts_queue, xbts_back
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  input    | in_valid / in_stall    | code_byte[7:0], last
//  output   | out_valid / out_stall  | target_addr[31:0], entry_index[31:0], is_final
//  config   | cfg_we                 | cfg_index[1:0], cfg_data[31:0]
//
// a byte per cycle while streaming if the queue has room; hits pass queue, s1, out reg
// on the last byte the flush sequencer checks one position a cycle while the queue has
// room, pushing hits; input stalls while the pending positions and the count item drain
// a four-entry job queue lets the back side stall without stopping the front until full
// reset clears the fill level, position, counts and all configuration registers to zero
module x86_branch_target_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  code_byte,
	input  logic        last,
	input  logic        in_valid,
	output logic        in_stall,
	output logic [31:0] target_addr,
	output logic [31:0] entry_index,
	output logic        is_final,
	output logic        out_valid,
	input  logic        out_stall,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import xbts_pkg::*;

	cfg_t cfg_q;
	logic q_push;
	job_t q_wr;
	logic q_full;
	logic q_pop;
	job_t q_head;
	logic q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEXT_BASE: cfg_q.text_base <= cfg_data;
				REG_CODE_SIZE: cfg_q.code_size <= cfg_data;
				REG_REBASE:    cfg_q.rebase    <= cfg_data;
				default: ;
			endcase
		end
	end

	xbts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.code_byte (code_byte),
		.last      (last),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wr)
	);

	xbts_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.full    (q_full),
		.pop     (q_pop),
		.head    (q_head),
		.empty   (q_empty)
	);

	xbts_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_head      (q_head),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.target_addr (target_addr),
		.entry_index (entry_index),
		.is_final    (is_final)
	);

endmodule
